// ===== sv/carv_pkg.sv =====
// ----------------------------------------------------------------------------
// carv_pkg
// shared constants, types and arithmetic helpers of the comb/allpass reverb
// ----------------------------------------------------------------------------
package carv_pkg;

    localparam int WORD_W    = 48;
    localparam int COEF_W    = 17;
    localparam int SAMPLE_W  = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 17;
    localparam int PLEN_W    = 12;

    localparam int DEF_COMB_SHORT_DELAY     = 1789;
    localparam int DEF_COMB_LONG_DELAY      = 1999;
    localparam int DEF_ALLPASS_FIRST_DELAY  = 433;
    localparam int DEF_ALLPASS_SECOND_DELAY = 149;
    localparam int DEF_CHANNEL_COUNT        = 3;
    localparam int DEF_PREDELAY_MAX         = 3200;

    localparam logic [COEF_W-1:0] Q16_ONE  = 17'd65536;
    localparam logic [COEF_W-1:0] K_POINT3 = 17'd19661;
    localparam logic [COEF_W-1:0] K_POINT6 = 17'd39322;

    localparam logic [CFG_IDX_W-1:0] REG_COMB_SHORT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COMB_LONG  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALLPASS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DAMPING    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WET        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PREDELAY   = 3'd5;

    typedef logic signed [WORD_W-1:0] word_t;

    typedef struct packed {
        logic [COEF_W-1:0] comb_short;
        logic [COEF_W-1:0] comb_long;
        logic [COEF_W-1:0] allpass;
        logic [COEF_W-1:0] damping;
        logic [COEF_W-1:0] wet;
        logic [COEF_W-1:0] dry;
        logic [PLEN_W-1:0] predelay_len;
    } cfg_t;

    function automatic word_t sat48(input logic signed [WORD_W+1:0] v);
        word_t r;
        if (v > $signed({2'b00, 1'b0, {(WORD_W-1){1'b1}}}))
            r = {1'b0, {(WORD_W-1){1'b1}}};
        else if (v < $signed({2'b11, 1'b1, {(WORD_W-1){1'b0}}}))
            r = {1'b1, {(WORD_W-1){1'b0}}};
        else
            r = v[WORD_W-1:0];
        return r;
    endfunction

    // q8 word times q16 coefficient, round half away from zero
    function automatic word_t qmul(input logic [COEF_W-1:0] g, input word_t x);
        logic [WORD_W-1:0]        mag;
        logic [WORD_W+COEF_W-1:0] p;
        logic [WORD_W-1:0]        q;
        mag = x[WORD_W-1] ? (~x + 1'b1) : x;
        p   = mag * g + (WORD_W+COEF_W)'(32'h8000);
        q   = p[WORD_W+15:16];
        return x[WORD_W-1] ? word_t'(~q + 1'b1) : word_t'(q);
    endfunction

    function automatic word_t add48(input word_t a, input word_t b);
        return sat48({{2{a[WORD_W-1]}}, a} + {{2{b[WORD_W-1]}}, b});
    endfunction

    function automatic word_t sub48(input word_t a, input word_t b);
        return sat48({{2{a[WORD_W-1]}}, a} - {{2{b[WORD_W-1]}}, b});
    endfunction

endpackage

// ===== sv/carv_cfg.sv =====
// ----------------------------------------------------------------------------
// carv_cfg
// configuration registers with clamping and mix gain derivation
// ----------------------------------------------------------------------------
module carv_cfg
    import carv_pkg::*;
#(
    parameter int PREDELAY_MAX = DEF_PREDELAY_MAX
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    output cfg_t                 cfg
);

    logic [COEF_W-1:0] cs_reg, cl_reg, ap_reg, dp_reg, wl_reg;
    logic [PLEN_W-1:0] pl_reg;
    logic [COEF_W-1:0] clamped;
    logic [COEF_W+COEF_W-1:0] wet_full;
    logic [COEF_W-1:0] wet;
    logic [PLEN_W:0]   plen_max;

    assign clamped  = (cfg_data > Q16_ONE) ? Q16_ONE : cfg_data;
    assign plen_max = (PLEN_W+1)'(PREDELAY_MAX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cs_reg <= '0;
            cl_reg <= '0;
            ap_reg <= '0;
            dp_reg <= '0;
            wl_reg <= '0;
            pl_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_COMB_SHORT: cs_reg <= clamped;
                REG_COMB_LONG:  cl_reg <= clamped;
                REG_ALLPASS:    ap_reg <= clamped;
                REG_DAMPING:    dp_reg <= clamped;
                REG_WET:        wl_reg <= clamped;
                REG_PREDELAY:
                begin
                    if ({1'b0, cfg_data[PLEN_W-1:0]} > plen_max)
                        pl_reg <= plen_max[PLEN_W-1:0];
                    else
                        pl_reg <= cfg_data[PLEN_W-1:0];
                end
                default: ;
            endcase
        end
    end

    assign wet_full = wl_reg * K_POINT6 + (2*COEF_W)'(32'h8000);
    assign wet      = wet_full[COEF_W+15:16];

    assign cfg.comb_short   = cs_reg;
    assign cfg.comb_long    = cl_reg;
    assign cfg.allpass      = ap_reg;
    assign cfg.damping      = dp_reg;
    assign cfg.wet          = wet;
    assign cfg.dry          = K_POINT6 - wet;
    assign cfg.predelay_len = pl_reg;

endmodule

// ===== sv/carv_ring.sv =====
// ----------------------------------------------------------------------------
// carv_ring
// one synchronous delay ring memory, one write and one registered read port
// ----------------------------------------------------------------------------
module carv_ring
    import carv_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  word_t                    wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output word_t                    rdata
);

    word_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/comb_allpass_reverb.sv =====
// ----------------------------------------------------------------------------
// comb_allpass_reverb
// three-channel schroeder style reverb: predelay, two combs, two allpasses
// ----------------------------------------------------------------------------
// channel   | dir | beat contents
// s_axis    | in  | tuser = channel_sel, tdata = in_sample
// m_axis    | out | tdata = out_sample
// cfg       | in  | cfg_we / cfg_index / cfg_data register write
//
// a sample passes through accept, ring read, six compute/write steps and
// the output load; no new sample is taken before its output load is done.
// an out-of-range channel gives a zero result next cycle.
// after reset a clearing pass over every address of the deepest ring
// zeroes all memories; no sample is taken meanwhile.
// a result held by a stalled output blocks the input until it is taken.
// ----------------------------------------------------------------------------
module comb_allpass_reverb
    import carv_pkg::*;
#(
    parameter int COMB_SHORT_DELAY     = DEF_COMB_SHORT_DELAY,
    parameter int COMB_LONG_DELAY      = DEF_COMB_LONG_DELAY,
    parameter int ALLPASS_FIRST_DELAY  = DEF_ALLPASS_FIRST_DELAY,
    parameter int ALLPASS_SECOND_DELAY = DEF_ALLPASS_SECOND_DELAY,
    parameter int CHANNEL_COUNT        = DEF_CHANNEL_COUNT,
    parameter int PREDELAY_MAX         = DEF_PREDELAY_MAX
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [31:0]          s_axis_tdata,  // [31:0] in_sample
    input  logic [1:0]           s_axis_tuser,  // [1:0] channel_sel
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [31:0]          m_axis_tdata,  // [31:0] out_sample
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    localparam int LEN_CS = COMB_SHORT_DELAY + 2;
    localparam int LEN_CL = COMB_LONG_DELAY + 2;
    localparam int LEN_A0 = ALLPASS_FIRST_DELAY + 2;
    localparam int LEN_A1 = ALLPASS_SECOND_DELAY + 2;
    localparam int D_CS = CHANNEL_COUNT * LEN_CS;
    localparam int D_CL = CHANNEL_COUNT * LEN_CL;
    localparam int D_A0 = CHANNEL_COUNT * LEN_A0;
    localparam int D_A1 = CHANNEL_COUNT * LEN_A1;
    localparam int D_PD = CHANNEL_COUNT * PREDELAY_MAX;
    localparam int AW_CS = $clog2(D_CS);
    localparam int AW_CL = $clog2(D_CL);
    localparam int AW_A0 = $clog2(D_A0);
    localparam int AW_A1 = $clog2(D_A1);
    localparam int AW_PD = $clog2(D_PD);
    localparam int D_M1  = (D_CS > D_CL) ? D_CS : D_CL;
    localparam int D_M2  = (D_A0 > D_A1) ? D_A0 : D_A1;
    localparam int D_M3  = (D_M1 > D_M2) ? D_M1 : D_M2;
    localparam int D_MAX = (D_PD > D_M3) ? D_PD : D_M3;
    localparam int CLR_W = $clog2(D_MAX + 1);
    localparam int PW    = 13;
    localparam int CHW   = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_RD    = 4'd2;
    localparam logic [3:0] ST_C1    = 4'd3;
    localparam logic [3:0] ST_C2    = 4'd4;
    localparam logic [3:0] ST_C3    = 4'd5;
    localparam logic [3:0] ST_C4    = 4'd6;
    localparam logic [3:0] ST_C5    = 4'd7;
    localparam logic [3:0] ST_C6    = 4'd8;
    localparam logic [3:0] ST_OUT   = 4'd9;

    cfg_t cfg;

    carv_cfg #(.PREDELAY_MAX(PREDELAY_MAX)) u_cfg (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .cfg(cfg)
    );

    logic [3:0]       state_reg, state_next;
    logic [CLR_W-1:0] clr_reg;
    logic [CHW-1:0]   ch_reg;
    word_t            x_reg;
    word_t            d_reg, cs_reg, cl_reg, a0_reg, a1_reg, lpin_reg, a1in_reg;
    word_t            lp_next;
    word_t            mix_reg;
    logic             oval_reg;
    logic [31:0]      odata_reg;

    // per-channel positions and last outputs, indexed by the held channel
    logic [PW-1:0] pos_reg  [CHANNEL_COUNT][5];
    word_t         last_reg [CHANNEL_COUNT][4];
    word_t         lpm_reg  [CHANNEL_COUNT];

    // ring addresses
    logic [PW-1:0] p_cs, p_cl, p_a0, p_a1, p_pd;
    logic [PW-1:0] r_cs, r_cl, r_a0, r_a1;
    logic [PW-1:0] n_cs, n_cl, n_a0, n_a1, n_pd;
    logic [PW-1:0] plen;
    logic          pd_on;

    function automatic logic [PW-1:0] wrap(input logic [PW-1:0] p, input int len);
        return (p >= PW'(len)) ? '0 : p;
    endfunction

    assign plen  = PW'(cfg.predelay_len);
    assign pd_on = (cfg.predelay_len != '0);
    assign p_cs  = wrap(pos_reg[ch_reg][0], LEN_CS);
    assign p_cl  = wrap(pos_reg[ch_reg][1], LEN_CL);
    assign p_a0  = wrap(pos_reg[ch_reg][2], LEN_A0);
    assign p_a1  = wrap(pos_reg[ch_reg][3], LEN_A1);
    assign p_pd  = (pos_reg[ch_reg][4] >= plen) ? '0 : pos_reg[ch_reg][4];
    assign r_cs  = (p_cs + PW'(2) >= PW'(LEN_CS)) ? p_cs + PW'(2) - PW'(LEN_CS)
                                                   : p_cs + PW'(2);
    assign r_cl  = (p_cl + PW'(2) >= PW'(LEN_CL)) ? p_cl + PW'(2) - PW'(LEN_CL)
                                                   : p_cl + PW'(2);
    assign r_a0  = (p_a0 + PW'(2) >= PW'(LEN_A0)) ? p_a0 + PW'(2) - PW'(LEN_A0)
                                                   : p_a0 + PW'(2);
    assign r_a1  = (p_a1 + PW'(2) >= PW'(LEN_A1)) ? p_a1 + PW'(2) - PW'(LEN_A1)
                                                   : p_a1 + PW'(2);
    assign n_cs  = (p_cs + PW'(1) >= PW'(LEN_CS)) ? '0 : p_cs + PW'(1);
    assign n_cl  = (p_cl + PW'(1) >= PW'(LEN_CL)) ? '0 : p_cl + PW'(1);
    assign n_a0  = (p_a0 + PW'(1) >= PW'(LEN_A0)) ? '0 : p_a0 + PW'(1);
    assign n_a1  = (p_a1 + PW'(1) >= PW'(LEN_A1)) ? '0 : p_a1 + PW'(1);
    assign n_pd  = (p_pd + PW'(1) >= plen) ? '0 : p_pd + PW'(1);

    logic [AW_CS-1:0] base_cs;
    logic [AW_CL-1:0] base_cl;
    logic [AW_A0-1:0] base_a0;
    logic [AW_A1-1:0] base_a1;
    logic [AW_PD-1:0] base_pd;
    assign base_cs = AW_CS'(ch_reg * LEN_CS);
    assign base_cl = AW_CL'(ch_reg * LEN_CL);
    assign base_a0 = AW_A0'(ch_reg * LEN_A0);
    assign base_a1 = AW_A1'(ch_reg * LEN_A1);
    assign base_pd = AW_PD'(ch_reg * PREDELAY_MAX);

    logic clearing;
    assign clearing = (state_reg == ST_CLEAR);

    // memory ports; reads of the ring positions happen in ST_RD
    logic             we_cs, we_cl, we_a0, we_a1, we_pd;
    logic [AW_CS-1:0] wa_cs, ra_cs;
    logic [AW_CL-1:0] wa_cl, ra_cl;
    logic [AW_A0-1:0] wa_a0, ra_a0;
    logic [AW_A1-1:0] wa_a1, ra_a1;
    logic [AW_PD-1:0] wa_pd, ra_pd;
    word_t            wd_cs, wd_cl, wd_a0, wd_a1, wd_pd;
    word_t            rd_cs, rd_cl, rd_a0, rd_a1, rd_pd;

    always_comb
    begin
        we_cs = 1'b0; we_cl = 1'b0; we_a0 = 1'b0; we_a1 = 1'b0; we_pd = 1'b0;
        wd_cs = '0; wd_cl = '0; wd_a0 = '0; wd_a1 = '0; wd_pd = '0;
        wa_cs = base_cs + AW_CS'(p_cs);
        wa_cl = base_cl + AW_CL'(p_cl);
        wa_a0 = base_a0 + AW_A0'(p_a0);
        wa_a1 = base_a1 + AW_A1'(p_a1);
        wa_pd = base_pd + AW_PD'(p_pd);
        ra_cs = base_cs + AW_CS'(r_cs);
        ra_cl = base_cl + AW_CL'(r_cl);
        ra_a0 = base_a0 + AW_A0'(r_a0);
        ra_a1 = base_a1 + AW_A1'(r_a1);
        ra_pd = wa_pd;
        if (clearing)
        begin
            wa_cs = AW_CS'(clr_reg); we_cs = (clr_reg < CLR_W'(D_CS));
            wa_cl = AW_CL'(clr_reg); we_cl = (clr_reg < CLR_W'(D_CL));
            wa_a0 = AW_A0'(clr_reg); we_a0 = (clr_reg < CLR_W'(D_A0));
            wa_a1 = AW_A1'(clr_reg); we_a1 = (clr_reg < CLR_W'(D_A1));
            wa_pd = AW_PD'(clr_reg); we_pd = (clr_reg < CLR_W'(D_PD));
        end
        else
        begin
            // write slots follow the model: ring read index differs from write
            we_pd = (state_reg == ST_C1) && pd_on; wd_pd = x_reg;
            we_cs = (state_reg == ST_C2); wd_cs = cs_reg;
            we_cl = (state_reg == ST_C2); wd_cl = cl_reg;
            we_a0 = (state_reg == ST_C4); wd_a0 = a0_reg;
            we_a1 = (state_reg == ST_C6); wd_a1 = a1in_reg;
        end
    end

    carv_ring #(.DEPTH(D_CS)) u_cs (.clk(clk), .we(we_cs), .waddr(wa_cs),
        .wdata(wd_cs), .raddr(ra_cs), .rdata(rd_cs));
    carv_ring #(.DEPTH(D_CL)) u_cl (.clk(clk), .we(we_cl), .waddr(wa_cl),
        .wdata(wd_cl), .raddr(ra_cl), .rdata(rd_cl));
    carv_ring #(.DEPTH(D_A0)) u_a0 (.clk(clk), .we(we_a0), .waddr(wa_a0),
        .wdata(wd_a0), .raddr(ra_a0), .rdata(rd_a0));
    carv_ring #(.DEPTH(D_A1)) u_a1 (.clk(clk), .we(we_a1), .waddr(wa_a1),
        .wdata(wd_a1), .raddr(ra_a1), .rdata(rd_a1));
    carv_ring #(.DEPTH(D_PD)) u_pd (.clk(clk), .we(we_pd), .waddr(wa_pd),
        .wdata(wd_pd), .raddr(ra_pd), .rdata(rd_pd));

    logic  in_acc, bad_ch, out_load;
    word_t din;
    word_t q_a, q_b;
    logic [WORD_W-1:0] mag;
    logic [WORD_W-9:0] imag;
    logic signed [WORD_W-8:0] qv;
    logic [31:0] sat_out;

    // input waits while a result is stuck at the output
    assign s_axis_tready = (state_reg == ST_IDLE) && (!oval_reg || m_axis_tready);
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign bad_ch = (32'(s_axis_tuser) >= CHANNEL_COUNT);
    assign din    = pd_on ? rd_pd : x_reg;
    assign out_load = (in_acc && bad_ch) ||
                      ((state_reg == ST_OUT) && (!oval_reg || m_axis_tready));

    // shared multiplier operands per step
    always_comb
    begin
        q_a = '0;
        q_b = '0;
        case (state_reg)
            ST_C1: begin q_a = qmul(cfg.comb_short, last_reg[ch_reg][0]);
                         q_b = qmul(cfg.comb_long,  last_reg[ch_reg][1]); end
            ST_C3: q_a = qmul(cfg.allpass, last_reg[ch_reg][2]);
            ST_C4: q_a = qmul(cfg.allpass, a0_reg);
            ST_C5: begin q_a = qmul(cfg.damping, lpm_reg[ch_reg]);
                         q_b = qmul(K_POINT3, lpin_reg); end
            ST_C6: q_a = qmul(cfg.allpass, a1in_reg);
            ST_OUT: begin q_a = qmul(cfg.dry, x_reg);
                          q_b = qmul(cfg.wet, a1_reg); end
            default: ;
        endcase
    end

    assign lp_next = add48(q_a, q_b);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (clr_reg == CLR_W'(D_MAX - 1)) state_next = ST_IDLE;
            ST_IDLE:  if (in_acc && !bad_ch) state_next = ST_RD;
            ST_RD:    state_next = ST_C1;
            ST_C1:    state_next = ST_C2;
            ST_C2:    state_next = ST_C3;
            ST_C3:    state_next = ST_C4;
            ST_C4:    state_next = ST_C5;
            ST_C5:    state_next = ST_C6;
            ST_C6:    state_next = ST_OUT;
            ST_OUT:   if (!oval_reg || m_axis_tready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            oval_reg  <= 1'b0;
            ch_reg    <= '0;
            for (int c = 0; c < CHANNEL_COUNT; c++)
            begin
                lpm_reg[c] <= '0;
                for (int k = 0; k < 5; k++) pos_reg[c][k] <= '0;
                for (int k = 0; k < 4; k++) last_reg[c][k] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (clearing) clr_reg <= clr_reg + 1'b1;
            if (out_load)
                oval_reg <= 1'b1;
            else if (oval_reg && m_axis_tready)
                oval_reg <= 1'b0;
            if (in_acc)
            begin
                ch_reg <= CHW'(s_axis_tuser);
                x_reg  <= word_t'($signed(s_axis_tdata)) <<< 8;
                // out-of-range channel yields zero and leaves state alone
                if (bad_ch)
                    odata_reg <= '0;
            end
            case (state_reg)
                ST_C1:
                begin
                    cs_reg <= add48(q_a, din);
                    cl_reg <= add48(q_b, din);
                    if (pd_on) pos_reg[ch_reg][4] <= n_pd;
                end
                ST_C2:
                begin
                    last_reg[ch_reg][0] <= rd_cs;
                    last_reg[ch_reg][1] <= rd_cl;
                    pos_reg[ch_reg][0]  <= n_cs;
                    pos_reg[ch_reg][1]  <= n_cl;
                    d_reg <= add48(rd_cs, rd_cl);
                end
                ST_C3: a0_reg <= add48(q_a, d_reg);
                ST_C4:
                begin
                    lpin_reg <= sub48(last_reg[ch_reg][2], q_a);
                    last_reg[ch_reg][2] <= rd_a0;
                    pos_reg[ch_reg][2]  <= n_a0;
                end
                ST_C5:
                begin
                    lpm_reg[ch_reg] <= lp_next;
                    a1in_reg <= add48(qmul(cfg.allpass, last_reg[ch_reg][3]), lp_next);
                end
                ST_C6:
                begin
                    a1_reg <= sub48(last_reg[ch_reg][3], q_a);
                    last_reg[ch_reg][3] <= rd_a1;
                    pos_reg[ch_reg][3]  <= n_a1;
                end
                ST_OUT:
                begin
                    if (!oval_reg || m_axis_tready)
                        odata_reg <= sat_out;
                end
                default: ;
            endcase
        end
    end

    // truncate toward zero, drop fraction, saturate to 32 bits
    assign mix_reg = lp_next;
    assign mag  = mix_reg[WORD_W-1] ? (~mix_reg + 1'b1) : mix_reg;
    assign imag = mag[WORD_W-1:8];
    assign qv   = mix_reg[WORD_W-1] ? -$signed({1'b0, imag}) : $signed({1'b0, imag});
    assign sat_out = (qv > 41'sh007FFFFFFF) ? 32'h7FFFFFFF :
                     (qv < -41'sh0080000000) ? 32'h80000000 : qv[31:0];

    assign m_axis_tvalid = oval_reg;
    assign m_axis_tdata  = odata_reg;

    ap_no_take_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !s_axis_tready)
        else $error("sample taken during clear");
    ap_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result dropped");
    ap_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD) |=> (state_reg == ST_C1))
        else $error("walk broken");

endmodule
